/* rtl/tbeng_pkg.sv */
`timescale 1ns / 1ps
// Package for the three-band envelope noise gate: widths, constants, codes, microprogram.
package tbeng_pkg;

  localparam int FRAC_BITS = 15;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam int ENG_W     = FRAC_BITS + 2;
  localparam int LVL_W     = 18;
  localparam int CFG_W     = 17;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = 4;
  localparam int SIZE_W    = 8;
  localparam int PC_W      = 6;

  localparam longint ONE_I  = longint'(1) << FRAC_BITS;
  localparam int K_SPAN     = int'((3 * ONE_I + 5) / 10);
  localparam int K_GATE_UP  = int'((8 * ONE_I + 50) / 100);
  localparam int K_GATE_DN  = int'((ONE_I + 5) / 10);

  // gate target: (excess << FRAC_BITS) / K_SPAN as excess * DIV_M >> DIV_S, exact below K_SPAN
  localparam int     DIV_S = 24;
  localparam longint DIV_M = ((longint'(1) << (DIV_S + FRAC_BITS)) + K_SPAN - 1) / K_SPAN;

  localparam int MA_W      = $clog2(DIV_M + 1);
  localparam int MB_W      = VAL_W;
  localparam int P_W       = MA_W + MB_W;

  localparam logic [VAL_W-1:0] ONE = VAL_W'(ONE_I);

  localparam int COUNT_K_LOW  = 6;
  localparam int COUNT_K_MID  = 5;
  localparam int COUNT_K_HIGH = 8;
  localparam int SHAPE_K_LOW  = 120;
  localparam int SHAPE_K_MID  = 100;
  localparam int SHAPE_K_HIGH = 60;
  localparam int SHAPE_B_LOW  = 20;
  localparam int SHAPE_B_MID  = 20;
  localparam int SHAPE_B_HIGH = 10;

  localparam logic [15:0]      RST_LOW_THR   = 16'd1966;
  localparam logic [15:0]      RST_MID_THR   = 16'd1475;
  localparam logic [15:0]      RST_HIGH_THR  = 16'd819;
  localparam logic [CFG_W-1:0] RST_FLOOR     = CFG_W'(13107);
  localparam logic [15:0]      RST_LOW_RATE  = 16'd1638;
  localparam logic [15:0]      RST_MID_RATE  = 16'd2294;
  localparam logic [15:0]      RST_HIGH_RATE = 16'd4915;
  localparam logic [15:0]      RST_ACTIVE    = 16'd655;

  typedef enum logic [IDX_W-1:0] {
    REG_LOW_THR, REG_MID_THR, REG_HIGH_THR, REG_NOISE_FLOOR,
    REG_LOW_RATE, REG_MID_RATE, REG_HIGH_RATE, REG_ACTIVE_LEVEL
  } reg_idx_t;

  typedef enum logic {CMD_LEVEL, CMD_TICK} cmd_t;
  typedef enum logic [1:0] {BAND_LOW, BAND_MID, BAND_HIGH, BAND_NONE} band_t;
  typedef enum logic [1:0] {SEL_LOW, SEL_MID, SEL_HIGH, SEL_GATE} sel_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD_APP, OP_APPLY, OP_ENERGY, OP_DIV,
    OP_LOAD_CNT, OP_STORE_CNT, OP_LOAD_SHP, OP_STORE_SHP, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {JC_NEXT, JC_SKIPDIV} jc_t;

  typedef struct packed {
    op_t             op;
    sel_t            sel;
    jc_t             jc;
    logic [PC_W-1:0] target;
  } uword_t;

  localparam logic [PC_W-1:0] ADDR_GATE = PC_W'(12);

  function automatic uword_t mk(input op_t op, input sel_t sel);
    uword_t w;
    w.op     = op;
    w.sel    = sel;
    w.jc     = JC_NEXT;
    w.target = '0;
    return w;
  endfunction

  // Tick program: smooth three bands, energy and gate target, gate, counts, sizes, emit.
  function automatic uword_t ucode(input logic [PC_W-1:0] addr);
    uword_t w;
    unique case (addr)
      PC_W'(0):  w = mk(OP_LOAD_APP,  SEL_LOW);
      PC_W'(1):  w = mk(OP_NOP,       SEL_LOW);
      PC_W'(2):  w = mk(OP_APPLY,     SEL_LOW);
      PC_W'(3):  w = mk(OP_LOAD_APP,  SEL_MID);
      PC_W'(4):  w = mk(OP_NOP,       SEL_MID);
      PC_W'(5):  w = mk(OP_APPLY,     SEL_MID);
      PC_W'(6):  w = mk(OP_LOAD_APP,  SEL_HIGH);
      PC_W'(7):  w = mk(OP_NOP,       SEL_HIGH);
      PC_W'(8):  w = mk(OP_APPLY,     SEL_HIGH);
      PC_W'(9):  begin
        w = mk(OP_ENERGY, SEL_GATE);
        w.jc = JC_SKIPDIV;
        w.target = ADDR_GATE;
      end
      PC_W'(10): w = mk(OP_NOP,       SEL_GATE);
      PC_W'(11): w = mk(OP_DIV,       SEL_GATE);
      PC_W'(12): w = mk(OP_LOAD_APP,  SEL_GATE);
      PC_W'(13): w = mk(OP_NOP,       SEL_GATE);
      PC_W'(14): w = mk(OP_APPLY,     SEL_GATE);
      PC_W'(15): w = mk(OP_LOAD_CNT,  SEL_LOW);
      PC_W'(16): w = mk(OP_NOP,       SEL_LOW);
      PC_W'(17): w = mk(OP_STORE_CNT, SEL_LOW);
      PC_W'(18): w = mk(OP_LOAD_CNT,  SEL_MID);
      PC_W'(19): w = mk(OP_NOP,       SEL_MID);
      PC_W'(20): w = mk(OP_STORE_CNT, SEL_MID);
      PC_W'(21): w = mk(OP_LOAD_CNT,  SEL_HIGH);
      PC_W'(22): w = mk(OP_NOP,       SEL_HIGH);
      PC_W'(23): w = mk(OP_STORE_CNT, SEL_HIGH);
      PC_W'(24): w = mk(OP_LOAD_SHP,  SEL_LOW);
      PC_W'(25): w = mk(OP_NOP,       SEL_LOW);
      PC_W'(26): w = mk(OP_STORE_SHP, SEL_LOW);
      PC_W'(27): w = mk(OP_LOAD_SHP,  SEL_MID);
      PC_W'(28): w = mk(OP_NOP,       SEL_MID);
      PC_W'(29): w = mk(OP_STORE_SHP, SEL_MID);
      PC_W'(30): w = mk(OP_LOAD_SHP,  SEL_HIGH);
      PC_W'(31): w = mk(OP_NOP,       SEL_HIGH);
      PC_W'(32): w = mk(OP_STORE_SHP, SEL_HIGH);
      default:   w = mk(OP_EMIT,      SEL_GATE);
    endcase
    return w;
  endfunction

endpackage

/* rtl/tbeng_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
interface tbeng_in_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [1:0]                      band;
  logic signed [tbeng_pkg::LVL_W-1:0] level;
  modport source (output valid, cmd, band, level, input ready);
  modport sink   (input valid, cmd, band, level, output ready);
endinterface

interface tbeng_out_if;
  logic                            valid;
  logic                            ready;
  logic [tbeng_pkg::VAL_W-1:0]     gate_level;
  logic                            active;
  logic [2:0]                      low_count;
  logic [2:0]                      mid_count;
  logic [3:0]                      high_count;
  logic [7:0]                      low_radius;
  logic [6:0]                      mid_side;
  logic [6:0]                      high_half;
  modport source (output valid, gate_level, active, low_count, mid_count, high_count,
                  low_radius, mid_side, high_half, input ready);
  modport sink   (input valid, gate_level, active, low_count, mid_count, high_count,
                  low_radius, mid_side, high_half, output ready);
endinterface

/* rtl/three_band_envelope_noise_gate_top.sv */
`timescale 1ns / 1ps
// Three-band envelope follower with energy noise gate. A level update item yields no
// result. A tick item runs a microprogram on a shared registered multiplier, skipping the
// reciprocal multiply that divides by 0.3 when the gate closes or its target saturates;
// its result then waits in the output register until taken. No new item is taken while a
// tick runs; items are taken while a result waits. Configuration is written by the user
// only while idle; the block itself does not enforce it.
module three_band_envelope_noise_gate_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [tbeng_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tbeng_pkg::CFG_W-1:0]    cfg_data,
  tbeng_in_if.sink                       in_ch,
  tbeng_out_if.source                    out_ch
);

  localparam int VAL_W = tbeng_pkg::VAL_W;
  localparam int FB    = tbeng_pkg::FRAC_BITS;

  // configuration
  logic [15:0]                  thr [3];
  logic [15:0]                  rate [3];
  logic [tbeng_pkg::CFG_W-1:0]  noise_floor;
  logic [15:0]                  active_level;

  // state
  logic [VAL_W-1:0] held [3];
  logic [VAL_W-1:0] smooth [3];
  logic [VAL_W-1:0] gate;

  // sequencer and datapath
  logic                           running;
  logic [tbeng_pkg::PC_W-1:0]     pc;
  tbeng_pkg::uword_t              uw;
  logic [tbeng_pkg::MA_W-1:0]     mul_a;
  logic [tbeng_pkg::MB_W-1:0]     mul_b;
  logic [tbeng_pkg::P_W-1:0]      prod;
  logic                           dir;
  logic                           gate_up;
  logic [VAL_W-1:0]               quo;
  logic [tbeng_pkg::CNT_W-1:0]    cnt_r [3];
  logic [tbeng_pkg::SIZE_W-1:0]   size_r [3];

  // output register
  logic                           out_valid;
  logic [VAL_W-1:0]               o_gate;
  logic                           o_active;
  logic [2:0]                     o_low_cnt;
  logic [2:0]                     o_mid_cnt;
  logic [3:0]                     o_high_cnt;
  logic [7:0]                     o_radius;
  logic [6:0]                     o_side;
  logic [6:0]                     o_half;

  // combinational
  logic                           in_acc;
  logic                           out_load;
  logic [tbeng_pkg::LVL_W-2:0]    lvl_mag;
  logic [VAL_W-1:0]               lvl_clamp;
  logic [VAL_W-1:0]               sm_sel;
  logic [VAL_W-1:0]               held_sel;
  logic [15:0]                    rate_sel;
  logic [VAL_W-1:0]               base;
  logic [VAL_W-1:0]               goal;
  logic [VAL_W-1:0]               frac;
  logic                           dir_c;
  logic [VAL_W-1:0]               mag;
  logic [VAL_W-1:0]               step;
  logic [VAL_W-1:0]               apply_val;
  logic [tbeng_pkg::MA_W-1:0]     cnt_k;
  logic [tbeng_pkg::MB_W-1:0]     shp_k;
  logic [tbeng_pkg::SIZE_W-1:0]   shp_b;
  logic [tbeng_pkg::ENG_W-1:0]    energy;
  logic [tbeng_pkg::ENG_W-1:0]    excess;
  logic                           up_c;
  logic                           sat_c;
  logic                           act_c;
  logic [1:0]                     bidx;

  assign uw           = tbeng_pkg::ucode(pc);
  assign in_ch.ready  = !running;
  assign in_acc       = in_ch.valid && !running;
  assign out_load     = running && (uw.op == tbeng_pkg::OP_EMIT) &&
                        (!out_valid || out_ch.ready);

  assign lvl_mag   = in_ch.level[tbeng_pkg::LVL_W-2:0];
  assign lvl_clamp = in_ch.level[tbeng_pkg::LVL_W-1] ? '0 :
                     (lvl_mag > (tbeng_pkg::LVL_W-1)'(tbeng_pkg::ONE)) ? tbeng_pkg::ONE :
                     lvl_mag[VAL_W-1:0];
  assign bidx      = in_ch.band;

  always_comb begin
    sm_sel   = '0;
    held_sel = '0;
    rate_sel = '0;
    cnt_k    = '0;
    shp_k    = '0;
    shp_b    = '0;
    unique case (uw.sel)
      tbeng_pkg::SEL_LOW: begin
        sm_sel   = smooth[0];
        held_sel = held[0];
        rate_sel = rate[0];
        cnt_k    = tbeng_pkg::MA_W'(tbeng_pkg::COUNT_K_LOW);
        shp_k    = tbeng_pkg::MB_W'(tbeng_pkg::SHAPE_K_LOW);
        shp_b    = tbeng_pkg::SIZE_W'(tbeng_pkg::SHAPE_B_LOW);
      end
      tbeng_pkg::SEL_MID: begin
        sm_sel   = smooth[1];
        held_sel = held[1];
        rate_sel = rate[1];
        cnt_k    = tbeng_pkg::MA_W'(tbeng_pkg::COUNT_K_MID);
        shp_k    = tbeng_pkg::MB_W'(tbeng_pkg::SHAPE_K_MID);
        shp_b    = tbeng_pkg::SIZE_W'(tbeng_pkg::SHAPE_B_MID);
      end
      tbeng_pkg::SEL_HIGH: begin
        sm_sel   = smooth[2];
        held_sel = held[2];
        rate_sel = rate[2];
        cnt_k    = tbeng_pkg::MA_W'(tbeng_pkg::COUNT_K_HIGH);
        shp_k    = tbeng_pkg::MB_W'(tbeng_pkg::SHAPE_K_HIGH);
        shp_b    = tbeng_pkg::SIZE_W'(tbeng_pkg::SHAPE_B_HIGH);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (uw.sel == tbeng_pkg::SEL_GATE) begin
      base = gate;
      goal = gate_up ? quo : '0;
      frac = gate_up ? VAL_W'(tbeng_pkg::K_GATE_UP) : VAL_W'(tbeng_pkg::K_GATE_DN);
    end else begin
      base = sm_sel;
      goal = held_sel;
      frac = (rate_sel > 16'(tbeng_pkg::ONE)) ? tbeng_pkg::ONE : VAL_W'(rate_sel);
    end
  end

  assign dir_c     = goal >= base;
  assign mag       = dir_c ? goal - base : base - goal;
  assign step      = prod[FB +: VAL_W];
  assign apply_val = dir ? base + step : base - step;

  assign energy = tbeng_pkg::ENG_W'(smooth[0]) + tbeng_pkg::ENG_W'(smooth[1]) +
                  tbeng_pkg::ENG_W'(smooth[2]);
  assign up_c   = energy > noise_floor;
  assign excess = energy - noise_floor;
  assign sat_c  = excess >= tbeng_pkg::ENG_W'(tbeng_pkg::K_SPAN);
  assign act_c  = gate > active_level;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (rst) begin
      thr[0]       <= tbeng_pkg::RST_LOW_THR;
      thr[1]       <= tbeng_pkg::RST_MID_THR;
      thr[2]       <= tbeng_pkg::RST_HIGH_THR;
      noise_floor  <= tbeng_pkg::RST_FLOOR;
      rate[0]      <= tbeng_pkg::RST_LOW_RATE;
      rate[1]      <= tbeng_pkg::RST_MID_RATE;
      rate[2]      <= tbeng_pkg::RST_HIGH_RATE;
      active_level <= tbeng_pkg::RST_ACTIVE;
      for (int i = 0; i < 3; i++) begin
        held[i]   <= '0;
        smooth[i] <= '0;
      end
      gate      <= '0;
      running   <= 1'b0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (tbeng_pkg::reg_idx_t'(cfg_index))
          tbeng_pkg::REG_LOW_THR:      thr[0]       <= cfg_data[15:0];
          tbeng_pkg::REG_MID_THR:      thr[1]       <= cfg_data[15:0];
          tbeng_pkg::REG_HIGH_THR:     thr[2]       <= cfg_data[15:0];
          tbeng_pkg::REG_NOISE_FLOOR:  noise_floor  <= cfg_data;
          tbeng_pkg::REG_LOW_RATE:     rate[0]      <= cfg_data[15:0];
          tbeng_pkg::REG_MID_RATE:     rate[1]      <= cfg_data[15:0];
          tbeng_pkg::REG_HIGH_RATE:    rate[2]      <= cfg_data[15:0];
          tbeng_pkg::REG_ACTIVE_LEVEL: active_level <= cfg_data[15:0];
          default: begin
          end
        endcase
      end

      if (out_valid && out_ch.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      if (in_acc) begin
        if (in_ch.cmd == tbeng_pkg::CMD_TICK) begin
          running <= 1'b1;
          pc      <= '0;
        end else if (bidx != tbeng_pkg::BAND_NONE) begin
          held[bidx] <= (lvl_clamp > thr[bidx]) ? lvl_clamp : '0;
        end
      end

      if (running) begin
        case (uw.op)
          tbeng_pkg::OP_LOAD_APP: begin
            mul_a <= tbeng_pkg::MA_W'(mag);
            mul_b <= frac;
            dir   <= dir_c;
          end
          tbeng_pkg::OP_APPLY: begin
            if (uw.sel == tbeng_pkg::SEL_GATE) begin
              gate <= apply_val;
            end else begin
              smooth[uw.sel] <= apply_val;
            end
          end
          tbeng_pkg::OP_ENERGY: begin
            gate_up <= up_c;
            quo     <= sat_c ? tbeng_pkg::ONE : '0;
            mul_a   <= tbeng_pkg::MA_W'(tbeng_pkg::DIV_M);
            mul_b   <= excess[tbeng_pkg::MB_W-1:0];
          end
          tbeng_pkg::OP_DIV: begin
            quo <= prod[tbeng_pkg::DIV_S +: VAL_W];
          end
          tbeng_pkg::OP_LOAD_CNT: begin
            mul_a <= tbeng_pkg::MA_W'(sm_sel) * cnt_k;
            mul_b <= gate;
          end
          tbeng_pkg::OP_STORE_CNT: begin
            cnt_r[uw.sel] <= prod[2*FB +: tbeng_pkg::CNT_W];
          end
          tbeng_pkg::OP_LOAD_SHP: begin
            mul_a <= tbeng_pkg::MA_W'(sm_sel);
            mul_b <= shp_k;
          end
          tbeng_pkg::OP_STORE_SHP: begin
            size_r[uw.sel] <= shp_b + prod[FB +: tbeng_pkg::SIZE_W];
          end
          default: begin
          end
        endcase

        if (uw.op == tbeng_pkg::OP_EMIT) begin
          if (out_load) begin
            running    <= 1'b0;
            out_valid  <= 1'b1;
            o_gate     <= gate;
            o_active   <= act_c;
            o_low_cnt  <= act_c ? cnt_r[0][2:0] : '0;
            o_mid_cnt  <= act_c ? cnt_r[1][2:0] : '0;
            o_high_cnt <= act_c ? cnt_r[2] : '0;
            o_radius   <= size_r[0];
            o_side     <= size_r[1][6:0];
            o_half     <= size_r[2][6:0];
          end
        end else begin
          unique case (uw.jc)
            tbeng_pkg::JC_SKIPDIV: pc <= (up_c && !sat_c) ? pc + 1'b1 : uw.target;
            default:               pc <= pc + 1'b1;
          endcase
        end
      end
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.gate_level = o_gate;
  assign out_ch.active     = o_active;
  assign out_ch.low_count  = o_low_cnt;
  assign out_ch.mid_count  = o_mid_cnt;
  assign out_ch.high_count = o_high_cnt;
  assign out_ch.low_radius = o_radius;
  assign out_ch.mid_side   = o_side;
  assign out_ch.high_half  = o_half;

endmodule
